[src/spq_pkg.sv]
// Shared types and constants for the sorted priority queue.
// Used by the controller, the datapath, the top level and the checker.
package spq_pkg;

  // Field widths and the default queue depth.
  localparam int unsigned DEPTH_DEF = 16;
  localparam int unsigned DATA_W    = 32;
  localparam int unsigned PRIO_W    = 8;
  localparam int unsigned MODE_W    = 2;
  localparam int unsigned STATUS_W  = 2;
  localparam int unsigned OCC_W     = 5;
  localparam int unsigned IN_TDATA_W  = 40;
  localparam int unsigned OUT_TDATA_W = 48;

  // Request codes.
  typedef enum logic [MODE_W-1:0] {
    MODE_INSERT   = 2'd0,
    MODE_POP      = 2'd1,
    MODE_EXACT    = 2'd2,
    MODE_AT_MOST  = 2'd3
  } mode_e;

  // Result codes.
  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK       = 2'd0,
    STATUS_FULL     = 2'd1,
    STATUS_EMPTY    = 2'd2,
    STATUS_NO_MATCH = 2'd3
  } status_e;

  // Controller states.
  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_INS_RD,
    S_INS_CMP,
    S_INS_PUT,
    S_SCAN_RD,
    S_SCAN_CMP,
    S_SH_RD,
    S_SH_WR,
    S_FIN_RM,
    S_DONE
  } state_e;

  // Read address choice relative to the working index.
  typedef enum logic [1:0] {
    RD_IDX_M1,
    RD_IDX,
    RD_IDX_P1
  } rd_sel_e;

  // Write choice: nothing, the entry just read, or the new entry.
  typedef enum logic [1:0] {
    WR_NONE,
    WR_SHIFT,
    WR_NEW
  } wr_sel_e;

  typedef enum logic [1:0] {
    IDX_HOLD,
    IDX_DEC,
    IDX_INC
  } idx_op_e;

  typedef enum logic [1:0] {
    CNT_HOLD,
    CNT_INC,
    CNT_DEC
  } cnt_op_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    load;
    rd_sel_e rd_sel;
    wr_sel_e wr_sel;
    idx_op_e idx_op;
    cnt_op_e cnt_op;
    logic    cap_out;
    logic    set_status;
    status_e status;
    logic    push;
  } spq_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic insert;
    logic full;
    logic empty;
    logic idx_zero;
    logic idx_one;
    logic prio_gt;
    logic hit;
    logic scan_more;
    logic shift_more;
    logic out_free;
  } spq_sts_t;

endpackage

[src/spq_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module spq_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[src/spq_ctrl.sv]
// Controller state machine of the sorted priority queue.
// Depends on spq_pkg; drives commands into spq_datapath.
module spq_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_valid_i,
  output logic             s_ready_o,
  input  spq_pkg::spq_sts_t sts_i,
  output spq_pkg::spq_cmd_t cmd_o
);
  import spq_pkg::*;

  state_e state_q, state_d;

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (s_valid_i) state_d = S_CHECK;
      end
      S_CHECK: begin
        if (sts_i.insert) begin
          if (sts_i.full)          state_d = S_DONE;
          else if (sts_i.idx_zero) state_d = S_INS_PUT;
          else                     state_d = S_INS_RD;
        end else if (sts_i.empty) begin
          state_d = S_DONE;
        end else begin
          state_d = S_SCAN_RD;
        end
      end
      S_INS_RD:  state_d = S_INS_CMP;
      S_INS_CMP: begin
        if (sts_i.prio_gt && !sts_i.idx_one) state_d = S_INS_RD;
        else                                 state_d = S_INS_PUT;
      end
      S_INS_PUT: state_d = S_DONE;
      S_SCAN_RD: state_d = S_SCAN_CMP;
      S_SCAN_CMP: begin
        if (sts_i.hit) begin
          state_d = sts_i.scan_more ? S_SH_RD : S_FIN_RM;
        end else begin
          state_d = sts_i.scan_more ? S_SCAN_RD : S_DONE;
        end
      end
      S_SH_RD: state_d = S_SH_WR;
      S_SH_WR: state_d = sts_i.shift_more ? S_SH_RD : S_FIN_RM;
      S_FIN_RM: state_d = S_DONE;
      S_DONE: begin
        if (sts_i.out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Command outputs.
  always_comb begin
    cmd_o            = '0;
    cmd_o.rd_sel     = RD_IDX;
    cmd_o.wr_sel     = WR_NONE;
    cmd_o.idx_op     = IDX_HOLD;
    cmd_o.cnt_op     = CNT_HOLD;
    cmd_o.status     = STATUS_OK;
    s_ready_o        = 1'b0;
    case (state_q)
      S_IDLE: begin
        s_ready_o  = 1'b1;
        cmd_o.load = s_valid_i;
      end
      S_CHECK: begin
        if (sts_i.insert && sts_i.full) begin
          cmd_o.set_status = 1'b1;
          cmd_o.status     = STATUS_FULL;
        end else if (!sts_i.insert && sts_i.empty) begin
          cmd_o.set_status = 1'b1;
          cmd_o.status     = STATUS_EMPTY;
        end
      end
      S_INS_RD: begin
        cmd_o.rd_sel = RD_IDX_M1;
      end
      S_INS_CMP: begin
        if (sts_i.prio_gt) begin
          cmd_o.wr_sel = WR_SHIFT;
          cmd_o.idx_op = IDX_DEC;
        end
      end
      S_INS_PUT: begin
        cmd_o.wr_sel = WR_NEW;
        cmd_o.cnt_op = CNT_INC;
      end
      S_SCAN_RD: begin
        cmd_o.rd_sel = RD_IDX;
      end
      S_SCAN_CMP: begin
        if (sts_i.hit) begin
          cmd_o.cap_out = 1'b1;
        end else begin
          cmd_o.idx_op = IDX_INC;
          if (!sts_i.scan_more) begin
            cmd_o.set_status = 1'b1;
            cmd_o.status     = STATUS_NO_MATCH;
          end
        end
      end
      S_SH_RD: begin
        cmd_o.rd_sel = RD_IDX_P1;
      end
      S_SH_WR: begin
        cmd_o.wr_sel = WR_SHIFT;
        cmd_o.idx_op = IDX_INC;
      end
      S_FIN_RM: begin
        cmd_o.cnt_op = CNT_DEC;
      end
      S_DONE: begin
        cmd_o.push = sts_i.out_free;
      end
      default: ;
    endcase
  end

endmodule

[src/spq_datapath.sv]
// Datapath of the sorted priority queue: entry RAM, index, count, result registers.
// Depends on spq_pkg and spq_ram; steered by spq_ctrl.
module spq_datapath #(
  parameter int unsigned DEPTH = spq_pkg::DEPTH_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  spq_pkg::spq_cmd_t                   cmd_i,
  output spq_pkg::spq_sts_t                   sts_o,
  input  logic [spq_pkg::MODE_W-1:0]          mode_i,
  input  logic signed [spq_pkg::DATA_W-1:0]   item_data_i,
  input  logic [spq_pkg::PRIO_W-1:0]          key_priority_i,
  input  logic                                m_ready_i,
  output logic                                m_valid_o,
  output logic [spq_pkg::STATUS_W-1:0]        status_o,
  output logic signed [spq_pkg::DATA_W-1:0]   out_data_o,
  output logic [spq_pkg::PRIO_W-1:0]          out_priority_o,
  output logic [spq_pkg::OCC_W-1:0]           occupancy_o
);
  import spq_pkg::*;

  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned EW = PRIO_W + DATA_W;
  localparam logic [CW:0] ONE_X = (CW + 1)'(1);
  localparam logic [CW:0] TWO_X = (CW + 1)'(2);

  // Request registers.
  mode_e                    mode_q;
  logic [PRIO_W-1:0]        key_q;
  logic signed [DATA_W-1:0] data_q;

  // Working index and entry count.
  logic [CW-1:0] idx_q, idx_d;
  logic [CW-1:0] count_q, count_d;

  // Result of the request in progress.
  status_e                  res_status_q;
  logic signed [DATA_W-1:0] res_data_q;
  logic [PRIO_W-1:0]        res_prio_q;

  // Output register.
  logic                     m_valid_q;
  status_e                  m_status_q;
  logic signed [DATA_W-1:0] m_data_q;
  logic [PRIO_W-1:0]        m_prio_q;
  logic [OCC_W-1:0]         m_occ_q;

  // Entry RAM port signals.
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [EW-1:0] ram_wdata;
  logic [AW-1:0] ram_raddr;
  logic [EW-1:0] ram_rdata;
  logic [CW-1:0] idx_m1;
  logic [CW-1:0] idx_p1;
  logic [CW-1:0] rd_full_addr;
  logic [PRIO_W-1:0] rd_prio;

  assign idx_m1  = idx_q - CW'(1);
  assign idx_p1  = idx_q + CW'(1);
  assign rd_prio = ram_rdata[EW-1:DATA_W];

  // Read address selection.
  always_comb begin
    case (cmd_i.rd_sel)
      RD_IDX_M1: rd_full_addr = idx_m1;
      RD_IDX_P1: rd_full_addr = idx_p1;
      default:   rd_full_addr = idx_q;
    endcase
  end
  assign ram_raddr = rd_full_addr[AW-1:0];

  // Write port: an entry moves to the working index, or the new entry lands there.
  always_comb begin
    ram_waddr = idx_q[AW-1:0];
    case (cmd_i.wr_sel)
      WR_SHIFT: begin
        ram_we    = 1'b1;
        ram_wdata = ram_rdata;
      end
      WR_NEW: begin
        ram_we    = 1'b1;
        ram_wdata = {key_q, data_q};
      end
      default: begin
        ram_we    = 1'b0;
        ram_wdata = ram_rdata;
      end
    endcase
  end

  spq_ram #(
    .WIDTH (EW),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Index and count updates.
  always_comb begin
    idx_d = idx_q;
    if (cmd_i.load) begin
      idx_d = (mode_e'(mode_i) == MODE_INSERT) ? count_q : '0;
    end else begin
      case (cmd_i.idx_op)
        IDX_DEC: idx_d = idx_m1;
        IDX_INC: idx_d = idx_p1;
        default: idx_d = idx_q;
      endcase
    end
    case (cmd_i.cnt_op)
      CNT_INC: count_d = count_q + CW'(1);
      CNT_DEC: count_d = count_q - CW'(1);
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  // Request and working result registers.
  always_ff @(posedge clk_i) begin
    idx_q <= idx_d;
    if (cmd_i.load) begin
      mode_q       <= mode_e'(mode_i);
      key_q        <= key_priority_i;
      data_q       <= item_data_i;
      res_status_q <= STATUS_OK;
      res_data_q   <= '0;
      res_prio_q   <= '0;
    end else begin
      if (cmd_i.set_status) res_status_q <= cmd_i.status;
      if (cmd_i.cap_out) begin
        res_data_q <= ram_rdata[DATA_W-1:0];
        res_prio_q <= rd_prio;
      end
    end
  end

  // Output register: holds a finished item until the sink takes it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (cmd_i.push) begin
      m_valid_q <= 1'b1;
    end else if (m_ready_i) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.push) begin
      m_status_q <= res_status_q;
      m_data_q   <= res_data_q;
      m_prio_q   <= res_prio_q;
      m_occ_q    <= OCC_W'(count_q);
    end
  end

  // Status toward the controller.
  always_comb begin
    sts_o.insert     = (mode_q == MODE_INSERT);
    sts_o.full       = (count_q == CW'(DEPTH));
    sts_o.empty      = (count_q == '0);
    sts_o.idx_zero   = (idx_q == '0);
    sts_o.idx_one    = (idx_q == CW'(1));
    sts_o.prio_gt    = (rd_prio > key_q);
    sts_o.scan_more  = (({1'b0, idx_q} + ONE_X) < {1'b0, count_q});
    sts_o.shift_more = (({1'b0, idx_q} + TWO_X) < {1'b0, count_q});
    sts_o.out_free   = !m_valid_q || m_ready_i;
    case (mode_q)
      MODE_POP:     sts_o.hit = 1'b1;
      MODE_EXACT:   sts_o.hit = (rd_prio == key_q);
      MODE_AT_MOST: sts_o.hit = (rd_prio <= key_q);
      default:      sts_o.hit = 1'b0;
    endcase
  end

  assign m_valid_o      = m_valid_q;
  assign status_o       = m_status_q;
  assign out_data_o     = m_data_q;
  assign out_priority_o = m_prio_q;
  assign occupancy_o    = m_occ_q;

endmodule

[src/sorted_priority_queue.sv]
// Top level of the sorted priority queue: stream ports, controller and datapath.
// Depends on spq_pkg, spq_ctrl, spq_datapath and spq_ram.
//
//  Channel | Direction | tuser         | tdata (lowest bit first)
//  s_axis  | in        | [1:0] mode    | [31:0] item_data, [39:32] key_priority
//  m_axis  | out       | [1:0] status  | [31:0] out_data, [39:32] out_priority,
//          |           |               | [44:40] occupancy, [47:45] zero
//
// One item is handled at a time. The entries live in one RAM with a registered
// read port, so every entry looked at or moved takes a read state and then a
// compare or write state. An insert moves each entry with a higher priority up,
// then writes the new one (one more entry is compared than is moved up unless
// all of them move). A removal scans from the head and moves the later entries
// down; one that finds nothing ends after the scan, and full and empty cases end
// after the check. The queue is empty after reset with no clearing pass. A
// finished item waits in the output register while the next item is accepted
// and worked on; that item then waits in its done state until the first is taken.
module sorted_priority_queue #(
  parameter int unsigned DEPTH = spq_pkg::DEPTH_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  logic [spq_pkg::IN_TDATA_W-1:0]       s_axis_tdata,  // item_data, key_priority
  input  logic [spq_pkg::MODE_W-1:0]           s_axis_tuser,  // mode
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  output logic [spq_pkg::OUT_TDATA_W-1:0]      m_axis_tdata,  // out_data, out_priority,
                                                              // occupancy
  output logic [spq_pkg::STATUS_W-1:0]         m_axis_tuser   // status
);
  import spq_pkg::*;

  spq_cmd_t cmd;
  spq_sts_t sts;

  logic signed [DATA_W-1:0] out_data;
  logic [PRIO_W-1:0]        out_priority;
  logic [OCC_W-1:0]         occupancy;

  spq_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  spq_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .mode_i         (s_axis_tuser),
    .item_data_i    (s_axis_tdata[DATA_W-1:0]),
    .key_priority_i (s_axis_tdata[DATA_W+PRIO_W-1:DATA_W]),
    .m_ready_i      (m_axis_tready),
    .m_valid_o      (m_axis_tvalid),
    .status_o       (m_axis_tuser),
    .out_data_o     (out_data),
    .out_priority_o (out_priority),
    .occupancy_o    (occupancy)
  );

  // Pack the result item, zero filled to whole bytes.
  assign m_axis_tdata = {(OUT_TDATA_W - DATA_W - PRIO_W - OCC_W)'(0),
                         occupancy, out_priority, out_data};

endmodule

[src/spq_checker.sv]
// Port-level checks for the sorted priority queue, bound to the top level.
// Depends on spq_pkg and sorted_priority_queue.
module spq_checker #(
  parameter int unsigned DEPTH = spq_pkg::DEPTH_DEF
) (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             s_axis_tvalid,
  input logic                             s_axis_tready,
  input logic                             m_axis_tvalid,
  input logic                             m_axis_tready,
  input logic [spq_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
  input logic [spq_pkg::STATUS_W-1:0]     m_axis_tuser
);
  import spq_pkg::*;

  logic [OCC_W-1:0] occ;
  assign occ = m_axis_tdata[DATA_W+PRIO_W+OCC_W-1:DATA_W+PRIO_W];

  // A stalled result item holds its payload.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result item changed while stalled");

  // The queue is busy right after it takes an item.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("accepted a second item in the next cycle");

  // A full report shows the queue at its depth.
  a_full_occ: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == STATUS_FULL) |-> (occ == OCC_W'(DEPTH)))
    else $error("full status with wrong occupancy");

  // An empty report shows no entries.
  a_empty_occ: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == STATUS_EMPTY) |-> (occ == '0))
    else $error("empty status with entries held");

  // A failed request returns no entry.
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser != STATUS_OK) |->
      (m_axis_tdata[DATA_W+PRIO_W-1:0] == '0))
    else $error("failed request returned an entry");

endmodule

bind sorted_priority_queue spq_checker #(
  .DEPTH (DEPTH)
) u_spq_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

[verif/tb_sorted_priority_queue.sv]
// Self-checking testbench for the sorted priority queue: directed table, then random traffic.
// Keeps its own sorted list of entries to predict every result; depends on spq_pkg
// and the sorted_priority_queue top level only.
module tb_sorted_priority_queue;
  import spq_pkg::*;

  localparam int unsigned DEPTH        = DEPTH_DEF;
  localparam int unsigned MAX_WAIT     = 14;
  localparam int unsigned DRAIN_CYCLES = 120;
  localparam int unsigned CYCLE_LIMIT  = 1_000_000;
  localparam int unsigned SEGMENTS     = 12;
  localparam int unsigned SEG_ITEMS    = 100;

  // One stored entry of the queue.
  typedef struct packed {
    logic [PRIO_W-1:0] prio;
    logic [DATA_W-1:0] data;
  } entry_t;

  // One result item as seen on the output stream.
  typedef struct packed {
    status_e           status;
    logic [DATA_W-1:0] data;
    logic [PRIO_W-1:0] prio;
    logic [OCC_W-1:0]  occ;
  } result_t;

  // One row of the directed table; fixed rows carry a hand-written result.
  typedef struct {
    mode_e             mode;
    logic [DATA_W-1:0] data;
    logic [PRIO_W-1:0] key;
    bit                fixed;
    result_t           want;
  } request_row_t;

  logic                   clk_i         = 1'b0;
  logic                   rst_ni        = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
  logic [MODE_W-1:0]      s_axis_tuser  = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic [STATUS_W-1:0]    m_axis_tuser;

  // Hand-written result that travels with the item being offered.
  bit      drv_fixed = 1'b0;
  result_t drv_want  = '0;

  entry_t       sorted_entries[$];
  result_t      pending_results[$];
  request_row_t directed_rows[$];

  int unsigned errors     = 0;
  int unsigned n_issued   = 0;
  int unsigned n_results  = 0;
  int unsigned rx_wait    = 0;
  int unsigned cycles     = 0;
  bit          burst      = 1'b0;

  sorted_priority_queue #(
    .DEPTH(DEPTH)
  ) u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  // Clock with a period of two time units.
  always #1 clk_i = ~clk_i;

  // Apply one request to the sorted entry list and return the result it causes.
  function automatic result_t apply_request(mode_e mode, logic [DATA_W-1:0] data,
                                            logic [PRIO_W-1:0] key);
    result_t res;
    entry_t  ent;
    int      slot;
    res        = '0;
    res.status = STATUS_OK;
    if (mode == MODE_INSERT) begin
      if (sorted_entries.size() >= DEPTH) begin
        res.status = STATUS_FULL;
      end else begin
        // Equal priorities stay behind older entries.
        slot = sorted_entries.size();
        while (slot > 0 && sorted_entries[slot-1].prio > key) slot--;
        ent.prio = key;
        ent.data = data;
        sorted_entries.insert(slot, ent);
      end
    end else if (sorted_entries.size() == 0) begin
      res.status = STATUS_EMPTY;
    end else begin
      slot = -1;
      if (mode == MODE_POP) begin
        slot = 0;
      end else begin
        foreach (sorted_entries[i]) begin
          if (slot < 0 && ((mode == MODE_EXACT) ? (sorted_entries[i].prio == key)
                                                : (sorted_entries[i].prio <= key))) begin
            slot = i;
          end
        end
      end
      if (slot < 0) begin
        res.status = STATUS_NO_MATCH;
      end else begin
        res.data = sorted_entries[slot].data;
        res.prio = sorted_entries[slot].prio;
        sorted_entries.delete(slot);
      end
    end
    res.occ = OCC_W'(sorted_entries.size());
    return res;
  endfunction

  task automatic report_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    end
  endtask

  task automatic add_row(mode_e mode, logic [DATA_W-1:0] data, logic [PRIO_W-1:0] key,
                         bit fixed, status_e status, logic [DATA_W-1:0] odata,
                         logic [PRIO_W-1:0] oprio, logic [OCC_W-1:0] occ);
    request_row_t row;
    row.mode        = mode;
    row.data        = data;
    row.key         = key;
    row.fixed       = fixed;
    row.want.status = status;
    row.want.data   = odata;
    row.want.prio   = oprio;
    row.want.occ    = occ;
    directed_rows.push_back(row);
  endtask

  // Offer one item after a random gap (none in burst mode) and hold it until it is accepted.
  task automatic issue_request(mode_e mode, logic [DATA_W-1:0] data, logic [PRIO_W-1:0] key,
                               bit fixed, result_t want);
    int unsigned gap;
    gap = burst ? 0 : $urandom_range(0, MAX_WAIT);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= mode;
    s_axis_tdata  <= {key, data};
    drv_fixed     <= fixed;
    drv_want      <= want;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    n_issued++;
  endtask

  // Hold off the sender until every issued item has produced its result.
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (n_results < n_issued) @(posedge clk_i);
  endtask

  // Output side: check each result item, record each accepted request, draw stalls.
  always @(posedge clk_i) begin
    result_t got;
    result_t want;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        n_results++;
        got.status = status_e'(m_axis_tuser);
        got.data   = m_axis_tdata[31:0];
        got.prio   = m_axis_tdata[39:32];
        got.occ    = m_axis_tdata[44:40];
        if (pending_results.size() == 0) begin
          errors++;
          $display("%0t: unexpected result, expected none, actual %0h", $time, got);
        end else begin
          want = pending_results.pop_front();
          report_field("status", 32'(want.status), 32'(got.status));
          report_field("out_data", want.data, got.data);
          report_field("out_priority", 32'(want.prio), 32'(got.prio));
          report_field("occupancy", 32'(want.occ), 32'(got.occ));
        end
        rx_wait = burst ? 0 : $urandom_range(0, MAX_WAIT);
      end
      if (s_axis_tvalid && s_axis_tready) begin
        want = apply_request(mode_e'(s_axis_tuser), s_axis_tdata[31:0], s_axis_tdata[39:32]);
        if (drv_fixed) want = drv_want;
        pending_results.push_back(want);
      end
      if (rx_wait > 0) begin
        rx_wait--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_sorted_priority_queue failed");
      $finish;
    end
  end

  // Stimulus: directed table first, then random segments.
  initial begin
    result_t           blank;
    mode_e             mode;
    logic [PRIO_W-1:0] key;
    int unsigned       insert_pct;
    int unsigned       span;
    int unsigned       key_base;
    blank = '0;

    // Empty queue, extremes of data and priority, ties, misses, then fill to full.
    add_row(MODE_POP, 32'h0, 8'h00, 1'b1, STATUS_EMPTY, 32'h0, 8'h00, 5'd0);
    add_row(MODE_EXACT, 32'h1234_5678, 8'hFF, 1'b1, STATUS_EMPTY, 32'h0, 8'h00, 5'd0);
    add_row(MODE_AT_MOST, 32'hFFFF_FFFF, 8'hFF, 1'b1, STATUS_EMPTY, 32'h0, 8'h00, 5'd0);
    add_row(MODE_INSERT, 32'h7FFF_FFFF, 8'hFF, 1'b1, STATUS_OK, 32'h0, 8'h00, 5'd1);
    add_row(MODE_INSERT, 32'h8000_0000, 8'h00, 1'b1, STATUS_OK, 32'h0, 8'h00, 5'd2);
    add_row(MODE_INSERT, 32'hFFFF_FFFF, 8'hFF, 1'b1, STATUS_OK, 32'h0, 8'h00, 5'd3);
    add_row(MODE_EXACT, 32'h0, 8'h07, 1'b1, STATUS_NO_MATCH, 32'h0, 8'h00, 5'd3);
    add_row(MODE_AT_MOST, 32'h0, 8'h00, 1'b1, STATUS_OK, 32'h8000_0000, 8'h00, 5'd2);
    add_row(MODE_AT_MOST, 32'h0, 8'hFE, 1'b1, STATUS_NO_MATCH, 32'h0, 8'h00, 5'd2);
    add_row(MODE_EXACT, 32'h0, 8'hFF, 1'b1, STATUS_OK, 32'h7FFF_FFFF, 8'hFF, 5'd1);
    for (int i = 0; i < DEPTH - 1; i++) begin
      add_row(MODE_INSERT, $urandom, (i % 3 == 0) ? 8'h80 : 8'($urandom_range(0, 255)),
              1'b0, STATUS_OK, 32'h0, 8'h00, 5'd0);
    end
    add_row(MODE_INSERT, 32'h0, 8'h80, 1'b1, STATUS_FULL, 32'h0, 8'h00, 5'(DEPTH));

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i]) begin
      issue_request(directed_rows[i].mode, directed_rows[i].data, directed_rows[i].key,
                    directed_rows[i].fixed, directed_rows[i].want);
    end
    wait_drained();

    // Random segments, each with its own insert rate, priority window and idling.
    for (int seg = 0; seg < SEGMENTS; seg++) begin
      case ($urandom_range(0, 2))
        0:       insert_pct = 15;
        1:       insert_pct = 50;
        default: insert_pct = 85;
      endcase
      case ($urandom_range(0, 2))
        0:       span = 3;
        1:       span = 15;
        default: span = 255;
      endcase
      key_base = $urandom_range(0, 255 - span);
      burst    = ($urandom_range(0, 3) == 0);
      for (int n = 0; n < SEG_ITEMS; n++) begin
        if (seg == SEGMENTS / 2 && n == 0) wait_drained();
        key = PRIO_W'(key_base + $urandom_range(0, span));
        if ($urandom_range(0, 99) < insert_pct) begin
          mode = MODE_INSERT;
        end else begin
          case ($urandom_range(1, 3))
            1:       mode = MODE_POP;
            2:       mode = MODE_EXACT;
            default: mode = MODE_AT_MOST;
          endcase
        end
        // Exact removals mostly aim at a priority that is present.
        if (mode == MODE_EXACT && sorted_entries.size() > 0 && $urandom_range(0, 9) < 7) begin
          key = sorted_entries[$urandom_range(0, sorted_entries.size() - 1)].prio;
        end
        issue_request(mode, $urandom, key, 1'b0, blank);
      end
    end
    burst = 1'b0;

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (pending_results.size() != 0) begin
      errors++;
      $display("%0t: results missing, expected %0d more, actual 0", $time,
               pending_results.size());
    end
    if (errors == 0) begin
      $display("tb_sorted_priority_queue passed");
    end else begin
      $display("tb_sorted_priority_queue failed");
    end
    $finish;
  end

endmodule
